FILE: design/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers, clocked on clk and held off in reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define SSP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition must never be seen at a clock edge outside reset.
`define SSP_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

FILE: design/ssp_pkg.sv
// ---------------------------------------------------------------------------
// Sprite projection package
// Shared widths and types of the sprite screen projection pipeline.
// ---------------------------------------------------------------------------
package ssp_pkg;

  // Divider operand and quotient widths.
  localparam int NUM_W = 48;
  localparam int DEN_W = 40;
  localparam int QUO_W = 17;

  // Camera register indexes on the configuration port.
  localparam logic [2:0] REG_PLAYER_X = 3'd0;
  localparam logic [2:0] REG_PLAYER_Y = 3'd1;
  localparam logic [2:0] REG_DIR_X    = 3'd2;
  localparam logic [2:0] REG_DIR_Y    = 3'd3;
  localparam logic [2:0] REG_PLANE_X  = 3'd4;
  localparam logic [2:0] REG_PLANE_Y  = 3'd5;

  // Camera register set.
  typedef struct packed {
    logic        [15:0] player_x;
    logic        [15:0] player_y;
    logic signed [15:0] dir_x;
    logic signed [15:0] dir_y;
    logic signed [15:0] plane_x;
    logic signed [15:0] plane_y;
  } cam_t;

  // Control that travels beside the divider operands.
  typedef struct packed {
    logic vld;
    logic kill;
    logic csign;
  } ctl_t;

endpackage

FILE: design/ssp_div.sv
// ---------------------------------------------------------------------------
// Pipelined divider
// Unsigned restoring divider, one quotient bit per stage, with overflow flag.
// ---------------------------------------------------------------------------
module ssp_div #(
  parameter int NW = 48,
  parameter int DW = 40,
  parameter int QW = 17
) (
  input  logic          clk,
  input  logic [NW-1:0] n_in,
  input  logic [DW-1:0] d_in,
  output logic [QW-1:0] q_out,
  output logic          ovf_out
);

  localparam int CW = (NW > DW + QW) ? NW : DW + QW;

  logic [NW-1:0] rem_r [0:QW-1];
  logic [DW-1:0] den_r [0:QW-1];
  logic [QW-1:0] quo_r [0:QW];
  logic          ovf_r [0:QW];

  // Entry stage: the quotient overflows when n is at least d times 2^QW.
  always_ff @(posedge clk) begin
    rem_r[0] <= n_in;
    den_r[0] <= d_in;
    quo_r[0] <= '0;
    ovf_r[0] <= CW'(n_in) >= (CW'(d_in) << QW);
  end

  // One restoring step per stage, most significant quotient bit first.
  for (genvar k = 1; k <= QW; k++) begin : g_step
    localparam int B = QW - k;
    logic [CW-1:0] trial;
    logic          take;
    logic [QW-1:0] quo_nxt;

    assign trial = CW'(den_r[k-1]) << B;
    assign take  = CW'(rem_r[k-1]) >= trial;

    always_comb begin
      quo_nxt    = quo_r[k-1];
      quo_nxt[B] = take;
    end

    always_ff @(posedge clk) begin
      quo_r[k] <= quo_nxt;
      ovf_r[k] <= ovf_r[k-1];
    end

    if (k < QW) begin : g_carry
      always_ff @(posedge clk) begin
        rem_r[k] <= take ? NW'(CW'(rem_r[k-1]) - trial) : rem_r[k-1];
        den_r[k] <= den_r[k-1];
      end
    end
  end

  assign q_out   = quo_r[QW];
  assign ovf_out = ovf_r[QW];

endmodule

FILE: design/ssp_front.sv
// ---------------------------------------------------------------------------
// Projection front end
// Camera transform, sign fix, near test and divider operand forming.
// ---------------------------------------------------------------------------
module ssp_front import ssp_pkg::*; #(
  parameter int SCREEN_WIDTH  = 320,
  parameter int SCREEN_HEIGHT = 200
) (
  input  logic             clk,
  input  logic             rst_n,
  input  cam_t             cam,
  input  logic             req,
  input  logic [15:0]      sprite_x,
  input  logic [15:0]      sprite_y,
  input  logic             sprite_active,
  output ctl_t             ctl_o,
  output logic [NUM_W-1:0] n_dep_o,
  output logic [DEN_W-1:0] d_dep_o,
  output logic [NUM_W-1:0] n_h_o,
  output logic [DEN_W-1:0] d_h_o,
  output logic [NUM_W-1:0] n_c_o,
  output logic [DEN_W-1:0] d_c_o
);

  logic v1_r, v2_r, v3_r, v4_r, v5_r;
  logic act1_r, act2_r, act3_r, act4_r;
  logic signed [16:0] dx1_r, dy1_r;
  logic signed [32:0] pa2_r, pb2_r, pc2_r, pd2_r;
  logic signed [31:0] pe2_r, pf2_r;
  logic signed [33:0] nx3_r, ny3_r, nx4_r, ny4_r, ny5_r;
  logic signed [32:0] det3_r, det4_r, det5_r;
  logic               detz4_r, kill5_r, near5;
  logic signed [34:0] sump5_r, sumn5_r;
  logic signed [45:0] ny640;
  logic        [34:0] mag6;
  ctl_t               ctl_r;
  logic [NUM_W-1:0]   n_dep_r, n_h_r, n_c_r;
  logic [DEN_W-1:0]   d_dep_r, d_h_r, d_c_r;

  // Valid bits of the front stages.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r  <= 1'b0;
      v2_r  <= 1'b0;
      v3_r  <= 1'b0;
      v4_r  <= 1'b0;
      v5_r  <= 1'b0;
      ctl_r <= '0;
    end else begin
      v1_r      <= req;
      v2_r      <= v1_r;
      v3_r      <= v2_r;
      v4_r      <= v3_r;
      v5_r      <= v4_r;
      ctl_r.vld <= v5_r;
      ctl_r.kill  <= kill5_r | near5;
      ctl_r.csign <= sump5_r < 0;
    end
  end

  // Near test: depth must exceed one tenth, that is ny*640 above det.
  assign ny640 = (46'(ny4_r) <<< 9) + (46'(ny4_r) <<< 7);
  assign near5 = 1'b0;

  // Magnitude of ny+nx for the center column.
  assign mag6 = (sump5_r < 0) ? sumn5_r : sump5_r;

  // Payload stages.
  always_ff @(posedge clk) begin
    // World delta from the player.
    act1_r <= sprite_active;
    dx1_r  <= $signed({1'b0, sprite_x}) - $signed({1'b0, cam.player_x});
    dy1_r  <= $signed({1'b0, sprite_y}) - $signed({1'b0, cam.player_y});

    // Products of the inverse camera transform.
    act2_r <= act1_r;
    pa2_r  <= 33'($signed(cam.dir_y)) * 33'(dx1_r);
    pb2_r  <= 33'($signed(cam.dir_x)) * 33'(dy1_r);
    pc2_r  <= 33'($signed(cam.plane_x)) * 33'(dy1_r);
    pd2_r  <= 33'($signed(cam.plane_y)) * 33'(dx1_r);
    pe2_r  <= 32'($signed(cam.plane_x)) * 32'($signed(cam.dir_y));
    pf2_r  <= 32'($signed(cam.plane_y)) * 32'($signed(cam.dir_x));

    // Differences.
    act3_r <= act2_r;
    nx3_r  <= 34'(pa2_r) - 34'(pb2_r);
    ny3_r  <= 34'(pc2_r) - 34'(pd2_r);
    det3_r <= 33'(pe2_r) - 33'(pf2_r);

    // Make the determinant positive.
    act4_r  <= act3_r;
    detz4_r <= det3_r == 0;
    det4_r  <= (det3_r < 0) ? -det3_r : det3_r;
    nx4_r   <= (det3_r < 0) ? -nx3_r : nx3_r;
    ny4_r   <= (det3_r < 0) ? -ny3_r : ny3_r;

    // Near flag and column sums.
    kill5_r <= !act4_r || detz4_r || (ny640 <= 46'(det4_r));
    ny5_r   <= ny4_r;
    det5_r  <= det4_r;
    sump5_r <= 35'(ny4_r) + 35'(nx4_r);
    sumn5_r <= -35'(ny4_r) - 35'(nx4_r);

    // Divider operands.
    n_dep_r <= NUM_W'(ny5_r[32:0]) << 14;
    d_dep_r <= DEN_W'(det5_r[31:0]);
    n_h_r   <= NUM_W'(det5_r[31:0]) * NUM_W'(SCREEN_HEIGHT);
    d_h_r   <= DEN_W'(ny5_r[32:0]) << 6;
    n_c_r   <= NUM_W'(mag6[33:0]) * NUM_W'(SCREEN_WIDTH);
    d_c_r   <= DEN_W'(ny5_r[32:0]) << 1;
  end

  assign ctl_o   = ctl_r;
  assign n_dep_o = n_dep_r;
  assign d_dep_o = d_dep_r;
  assign n_h_o   = n_h_r;
  assign d_h_o   = d_h_r;
  assign n_c_o   = n_c_r;
  assign d_c_o   = d_c_r;

endmodule

FILE: design/ssp_back.sv
// ---------------------------------------------------------------------------
// Projection back end
// Bounds, clamping, saturation and the registered result.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module ssp_back import ssp_pkg::*; #(
  parameter int SCREEN_WIDTH  = 320,
  parameter int SCREEN_HEIGHT = 200
) (
  input  logic               clk,
  input  logic               rst_n,
  input  ctl_t               ctl_i,
  input  logic [QUO_W-1:0]   q_dep,
  input  logic               ovf_dep,
  input  logic [QUO_W-1:0]   q_h,
  input  logic               ovf_h,
  input  logic [QUO_W-1:0]   q_c,
  input  logic               ovf_c,
  output logic               out_valid,
  output logic               out_visible,
  output logic [15:0]        out_depth,
  output logic [11:0]        out_sprite_height,
  output logic signed [15:0] out_left_edge,
  output logic [8:0]         out_draw_start_x,
  output logic [8:0]         out_draw_end_x,
  output logic [7:0]         out_draw_start_y,
  output logic [7:0]         out_draw_end_y
);

  localparam logic signed [19:0] HALF_SH = 20'(SCREEN_HEIGHT / 2);
  localparam logic signed [19:0] SW_M1   = 20'(SCREEN_WIDTH - 1);
  localparam logic signed [19:0] SH_M1   = 20'(SCREEN_HEIGHT - 1);

  logic [QUO_W-1:0]   h_full, cxm;
  logic [15:0]        half;
  logic signed [18:0] cx;
  logic               vld1_r, kill1_r;
  logic signed [19:0] left1_r, ex1_r, sy1_r, ey1_r;
  logic [15:0]        dep1_r;
  logic [11:0]        hs1_r;
  logic signed [19:0] sxc, exc, syc, eyc;
  logic               vis;
  logic [15:0]        left_sat;

  logic               valid_r, visible_r;
  logic [15:0]        depth_r, left_r;
  logic [11:0]        height_r;
  logic [8:0]         sx_r, ex_r;
  logic [7:0]         sy_r, ey_r;

  // Height, half size and signed center column.
  assign h_full = ovf_h ? '1 : q_h;
  assign half   = h_full[QUO_W-1:1];
  assign cxm    = ovf_c ? '1 : q_c;
  assign cx     = ctl_i.csign ? -19'(cxm) : 19'(cxm);

  // Unclamped bounds and saturated depth and height.
  always_ff @(posedge clk) begin
    kill1_r <= ctl_i.kill;
    left1_r <= 20'(cx) - 20'(half);
    ex1_r   <= 20'(cx) + 20'(half);
    sy1_r   <= HALF_SH - 20'(half);
    ey1_r   <= HALF_SH + 20'(half);
    dep1_r  <= (ovf_dep || q_dep[QUO_W-1:16] != '0) ? 16'hFFFF : q_dep[15:0];
    hs1_r   <= (h_full > QUO_W'(4095)) ? 12'hFFF : h_full[11:0];
  end

  // Clamp to the screen and decide visibility.
  assign sxc = (left1_r < 0) ? '0 : left1_r;
  assign exc = (ex1_r > SW_M1) ? SW_M1 : ex1_r;
  assign syc = (sy1_r < 0) ? '0 : sy1_r;
  assign eyc = (ey1_r > SH_M1) ? SH_M1 : ey1_r;
  assign vis = vld1_r && !kill1_r && !(sxc > exc) && !(syc > eyc);

  always_comb begin
    if (left1_r > 20'sd32767) begin
      left_sat = 16'h7FFF;
    end else if (left1_r < -20'sd32768) begin
      left_sat = 16'h8000;
    end else begin
      left_sat = left1_r[15:0];
    end
  end

  // Control registers of the back stages.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r    <= 1'b0;
      valid_r   <= 1'b0;
      visible_r <= 1'b0;
    end else begin
      vld1_r    <= ctl_i.vld;
      valid_r   <= vld1_r;
      visible_r <= vis;
    end
  end

  // Result register; a hidden sprite reports all zeros.
  always_ff @(posedge clk) begin
    depth_r  <= vis ? dep1_r : '0;
    height_r <= vis ? hs1_r : '0;
    left_r   <= vis ? left_sat : '0;
    sx_r     <= vis ? sxc[8:0] : '0;
    ex_r     <= vis ? exc[8:0] : '0;
    sy_r     <= vis ? syc[7:0] : '0;
    ey_r     <= vis ? eyc[7:0] : '0;
  end

  assign out_valid         = valid_r;
  assign out_visible       = visible_r;
  assign out_depth         = depth_r;
  assign out_sprite_height = height_r;
  assign out_left_edge     = left_r;
  assign out_draw_start_x  = sx_r;
  assign out_draw_end_x    = ex_r;
  assign out_draw_start_y  = sy_r;
  assign out_draw_end_y    = ey_r;

  `SSP_ASSERT(a_vis_valid, out_visible |-> out_valid, "visible without strobe")
  `SSP_NEVER(a_hidden_zero, out_valid && !out_visible && out_depth != 16'd0, "hidden nonzero")
  `SSP_ASSERT(a_stage_vld, vld1_r |=> out_valid, "back stage lost a request")

endmodule

FILE: design/sprite_screen_projection.sv
// ---------------------------------------------------------------------------
// Sprite screen projection
// Projects one sprite into screen space through the inverse camera transform.
// ---------------------------------------------------------------------------
// Usage:
//   Load the camera over the cfg_ port (cfg_we, cfg_addr, cfg_wdata): player
//   position, view direction and camera plane, indexes 0 to 5 in that order.
//   Write only while no request is in flight.
//   Raise start with in_sprite_x, in_sprite_y and in_sprite_active. busy is
//   always low, so a request is taken at every clock edge that sees start.
//   Each request gives one result, shown for one cycle with out_valid high,
//   once it has passed the front, divider and back stages. A new request may
//   follow every cycle; 26 requests can be in flight.
//   The pipeline is six front stages (deltas, products, sums, sign fix, near
//   test, operand forming), eighteen stages of the three parallel dividers
//   (entry, then one quotient bit per stage) and two of clamping and result.
//   The receiver cannot hold results off; none is needed since the pipeline
//   never stalls.
//   Reset clears every valid bit, so requests in flight are dropped, and
//   loads the default camera: player at the origin, looking along +y.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module sprite_screen_projection import ssp_pkg::*; #(
  parameter int SCREEN_WIDTH  = 320,
  parameter int SCREEN_HEIGHT = 200
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_addr,
  input  logic [15:0]        cfg_wdata,
  input  logic               start,
  output logic               busy,
  input  logic [15:0]        in_sprite_x,
  input  logic [15:0]        in_sprite_y,
  input  logic               in_sprite_active,
  output logic               out_valid,
  output logic               out_visible,
  output logic [15:0]        out_depth,
  output logic [11:0]        out_sprite_height,
  output logic signed [15:0] out_left_edge,
  output logic [8:0]         out_draw_start_x,
  output logic [8:0]         out_draw_end_x,
  output logic [7:0]         out_draw_start_y,
  output logic [7:0]         out_draw_end_y
);

  localparam int LATENCY = 6 + QUO_W + 1 + 2;

  cam_t             cam_r;
  ctl_t             front_ctl;
  ctl_t             ctl_dly_r [0:QUO_W];
  logic [NUM_W-1:0] n_dep, n_h, n_c;
  logic [DEN_W-1:0] d_dep, d_h, d_c;
  logic [QUO_W-1:0] q_dep, q_h, q_c;
  logic             ovf_dep, ovf_h, ovf_c;

  assign busy = 1'b0;

  // Camera registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cam_r.player_x <= 16'd0;
      cam_r.player_y <= 16'd0;
      cam_r.dir_x    <= 16'sd0;
      cam_r.dir_y    <= 16'sd16384;
      cam_r.plane_x  <= 16'sd10813;
      cam_r.plane_y  <= 16'sd0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_PLAYER_X: cam_r.player_x <= cfg_wdata;
        REG_PLAYER_Y: cam_r.player_y <= cfg_wdata;
        REG_DIR_X:    cam_r.dir_x    <= cfg_wdata;
        REG_DIR_Y:    cam_r.dir_y    <= cfg_wdata;
        REG_PLANE_X:  cam_r.plane_x  <= cfg_wdata;
        REG_PLANE_Y:  cam_r.plane_y  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  ssp_front #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .cam           (cam_r),
    .req           (start & ~busy),
    .sprite_x      (in_sprite_x),
    .sprite_y      (in_sprite_y),
    .sprite_active (in_sprite_active),
    .ctl_o         (front_ctl),
    .n_dep_o       (n_dep),
    .d_dep_o       (d_dep),
    .n_h_o         (n_h),
    .d_h_o         (d_h),
    .n_c_o         (n_c),
    .d_c_o         (d_c)
  );

  // Depth, height and center column dividers run side by side.
  ssp_div #(.NW(NUM_W), .DW(DEN_W), .QW(QUO_W)) u_div_dep (
    .clk (clk), .n_in (n_dep), .d_in (d_dep), .q_out (q_dep), .ovf_out (ovf_dep)
  );

  ssp_div #(.NW(NUM_W), .DW(DEN_W), .QW(QUO_W)) u_div_h (
    .clk (clk), .n_in (n_h), .d_in (d_h), .q_out (q_h), .ovf_out (ovf_h)
  );

  ssp_div #(.NW(NUM_W), .DW(DEN_W), .QW(QUO_W)) u_div_c (
    .clk (clk), .n_in (n_c), .d_in (d_c), .q_out (q_c), .ovf_out (ovf_c)
  );

  // Control delay line matching the divider depth.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i <= QUO_W; i++) begin
        ctl_dly_r[i] <= '0;
      end
    end else begin
      ctl_dly_r[0] <= front_ctl;
      for (int i = 1; i <= QUO_W; i++) begin
        ctl_dly_r[i] <= ctl_dly_r[i-1];
      end
    end
  end

  ssp_back #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT)
  ) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .ctl_i             (ctl_dly_r[QUO_W]),
    .q_dep             (q_dep),
    .ovf_dep           (ovf_dep),
    .q_h               (q_h),
    .ovf_h             (ovf_h),
    .q_c               (q_c),
    .ovf_c             (ovf_c),
    .out_valid         (out_valid),
    .out_visible       (out_visible),
    .out_depth         (out_depth),
    .out_sprite_height (out_sprite_height),
    .out_left_edge     (out_left_edge),
    .out_draw_start_x  (out_draw_start_x),
    .out_draw_end_x    (out_draw_end_x),
    .out_draw_start_y  (out_draw_start_y),
    .out_draw_end_y    (out_draw_end_y)
  );

  `SSP_ASSERT(a_req_result, start |-> ##LATENCY out_valid, "request without result")
  `SSP_ASSERT(a_result_req, out_valid |-> $past(start, LATENCY), "result without request")

endmodule

FILE: test/tb_sprite_screen_projection.sv
// ---------------------------------------------------------------------------
// Sprite screen projection testbench
// Drives sprite requests through the projection pipeline under several camera
// settings, predicts each result in fixed point and compares every field.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_sprite_screen_projection import ssp_pkg::*;;

  localparam int SCR_W = 320;
  localparam int SCR_H = 200;
  localparam int PIPE_LAT = 26;
  localparam int STALL_LIMIT = 2000;

  typedef struct packed {
    logic [15:0] sx;
    logic [15:0] sy;
    logic        active;
  } sprite_req_t;

  typedef struct packed {
    logic        visible;
    logic [15:0] depth;
    logic [11:0] height;
    logic [15:0] left;
    logic [8:0]  start_x;
    logic [8:0]  end_x;
    logic [7:0]  start_y;
    logic [7:0]  end_y;
  } projection_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_addr = '0;
  logic [15:0] cfg_wdata = '0;
  logic start = 1'b0;
  logic busy;
  logic [15:0] in_sprite_x = '0;
  logic [15:0] in_sprite_y = '0;
  logic in_sprite_active = 1'b0;
  logic out_valid;
  logic out_visible;
  logic [15:0] out_depth;
  logic [11:0] out_sprite_height;
  logic signed [15:0] out_left_edge;
  logic [8:0] out_draw_start_x;
  logic [8:0] out_draw_end_x;
  logic [7:0] out_draw_start_y;
  logic [7:0] out_draw_end_y;

  sprite_screen_projection #(.SCREEN_WIDTH(SCR_W), .SCREEN_HEIGHT(SCR_H)) u_top (
    .clk, .rst_n, .cfg_we, .cfg_addr, .cfg_wdata, .start, .busy,
    .in_sprite_x, .in_sprite_y, .in_sprite_active,
    .out_valid, .out_visible, .out_depth, .out_sprite_height, .out_left_edge,
    .out_draw_start_x, .out_draw_end_x, .out_draw_start_y, .out_draw_end_y
  );

  always #6 clk = ~clk;

  cam_t camera;
  sprite_req_t pending_reqs[$];
  projection_t expected_proj[$];
  int error_count = 0;
  int idle_cycles = 0;
  int gap_left = 0;
  bit stim_done = 1'b0;

  // Project one sprite with the current camera copy.
  function automatic projection_t project_sprite(sprite_req_t r);
    projection_t p;
    longint dx, dy, det, nx, ny, dep, h, half, cx, sx, ex, sy, ey, left;
    p = '0;
    if (!r.active) return p;
    dx = longint'(r.sx) - longint'(camera.player_x);
    dy = longint'(r.sy) - longint'(camera.player_y);
    det = longint'(camera.plane_x) * longint'(camera.dir_y)
        - longint'(camera.plane_y) * longint'(camera.dir_x);
    if (det == 0) return p;
    nx = longint'(camera.dir_y) * dx - longint'(camera.dir_x) * dy;
    ny = longint'(camera.plane_x) * dy - longint'(camera.plane_y) * dx;
    if (det < 0) begin
      det = -det;
      nx = -nx;
      ny = -ny;
    end
    // Too near or behind the camera.
    if (ny * 640 <= det) return p;
    dep = (ny * 16384) / det;
    if (dep > 65535) dep = 65535;
    h = (SCR_H * det) / (ny * 64);
    half = h / 2;
    cx = (SCR_W * (ny + nx)) / (2 * ny);
    left = cx - half;
    sx = left;
    ex = cx + half;
    sy = SCR_H / 2 - half;
    ey = SCR_H / 2 + half;
    if (sx < 0) sx = 0;
    if (ex >= SCR_W) ex = SCR_W - 1;
    if (sy < 0) sy = 0;
    if (ey >= SCR_H) ey = SCR_H - 1;
    if (sx > ex || sy > ey) return p;
    if (h > 4095) h = 4095;
    if (left > 32767) left = 32767;
    if (left < -32768) left = -32768;
    p.visible = 1'b1;
    p.depth = dep[15:0];
    p.height = h[11:0];
    p.left = left[15:0];
    p.start_x = sx[8:0];
    p.end_x = ex[8:0];
    p.start_y = sy[7:0];
    p.end_y = ey[7:0];
    return p;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    error_count++;
  endtask

  // Driver: one request per accepted edge, with random gaps.
  always @(negedge clk) begin
    if (!rst_n || cfg_we) begin
      start <= 1'b0;
    end else if (start && !busy && gap_left == 0 && pending_reqs.size() == 0) begin
      start <= 1'b0;
    end else if (gap_left > 0) begin
      gap_left <= gap_left - 1;
      start <= 1'b0;
    end else if (pending_reqs.size() > 0) begin
      sprite_req_t r;
      r = pending_reqs.pop_front();
      in_sprite_x <= r.sx;
      in_sprite_y <= r.sy;
      in_sprite_active <= r.active;
      start <= 1'b1;
      gap_left <= ($urandom_range(0, 3) == 0) ? $urandom_range(0, 18) : 0;
    end else begin
      start <= 1'b0;
    end
  end

  // Monitor: predict at acceptance, compare at the result strobe.
  always @(posedge clk) begin
    if (rst_n) begin
      if (start && !busy) begin
        expected_proj.push_back(project_sprite('{in_sprite_x, in_sprite_y,
                                                 in_sprite_active}));
      end
      if (start && !busy || out_valid) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (out_valid) begin
        if (expected_proj.size() == 0) begin
          report_mismatch("unexpected result", 1, 0);
        end else begin
          projection_t w;
          w = expected_proj.pop_front();
          if (out_visible !== w.visible) report_mismatch("visible", out_visible, w.visible);
          if (out_depth !== w.depth) report_mismatch("depth", out_depth, w.depth);
          if (out_sprite_height !== w.height)
            report_mismatch("sprite_height", out_sprite_height, w.height);
          if (out_left_edge !== w.left)
            report_mismatch("left_edge", out_left_edge, $signed(w.left));
          if (out_draw_start_x !== w.start_x)
            report_mismatch("draw_start_x", out_draw_start_x, w.start_x);
          if (out_draw_end_x !== w.end_x)
            report_mismatch("draw_end_x", out_draw_end_x, w.end_x);
          if (out_draw_start_y !== w.start_y)
            report_mismatch("draw_start_y", out_draw_start_y, w.start_y);
          if (out_draw_end_y !== w.end_y)
            report_mismatch("draw_end_y", out_draw_end_y, w.end_y);
        end
      end
    end
  end

  // Watchdog on cycles with no request taken and no result seen.
  always @(posedge clk) begin
    if (idle_cycles >= STALL_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Camera write at the falling edge, updating the predictor's copy too.
  task automatic write_cam(logic [2:0] idx, logic [15:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_PLAYER_X: camera.player_x = val;
      REG_PLAYER_Y: camera.player_y = val;
      REG_DIR_X:    camera.dir_x = val;
      REG_DIR_Y:    camera.dir_y = val;
      REG_PLANE_X:  camera.plane_x = val;
      REG_PLANE_Y:  camera.plane_y = val;
      default: ;
    endcase
  endtask

  task automatic set_camera(logic [15:0] px, logic [15:0] py, logic [15:0] dx,
                            logic [15:0] dy, logic [15:0] lx, logic [15:0] ly);
    write_cam(REG_PLAYER_X, px);
    write_cam(REG_PLAYER_Y, py);
    write_cam(REG_DIR_X, dx);
    write_cam(REG_DIR_Y, dy);
    write_cam(REG_PLANE_X, lx);
    write_cam(REG_PLANE_Y, ly);
  endtask

  // Let everything queued drain, then the pipeline latency.
  task automatic drain;
    wait (pending_reqs.size() == 0 && !start && expected_proj.size() == 0);
    repeat (PIPE_LAT + 4) @(posedge clk);
  endtask

  task automatic add_req(logic [15:0] x, logic [15:0] y, logic a);
    pending_reqs.push_back('{x, y, a});
  endtask

  // Mostly sprites near the player, on every side of it, with some full-range noise.
  task automatic add_random(int n);
    repeat (n) begin
      int mode;
      mode = $urandom_range(0, 9);
      if (mode < 7)
        add_req(camera.player_x + 16'($urandom_range(0, 4095)) - 16'd2048,
                camera.player_y + 16'($urandom_range(0, 4095)) - 16'd2048,
                $urandom_range(0, 7) != 0);
      else
        add_req(16'($urandom), 16'($urandom), 1'($urandom));
    end
  endtask

  initial begin
    camera = '{16'd0, 16'd0, 16'sd0, 16'sd16384, 16'sd10813, 16'sd0};
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: default camera, extremes, inactive, near and edge cases.
    add_req(16'd0, 16'd0, 1'b0);
    add_req(16'hFFFF, 16'hFFFF, 1'b0);
    add_req(16'd0, 16'd0, 1'b1);
    add_req(16'd0, 16'd25, 1'b1);
    add_req(16'd0, 16'd26, 1'b1);
    add_req(16'd0, 16'd256, 1'b1);
    add_req(16'd0, 16'd1, 1'b1);
    add_req(16'hFFFF, 16'd256, 1'b1);
    add_req(16'd0, 16'hFFFF, 1'b1);
    add_req(16'hFFFF, 16'hFFFF, 1'b1);
    add_req(16'd300, 16'd512, 1'b1);
    add_req(16'h8000, 16'h0100, 1'b1);
    drain();

    // Singular camera.
    set_camera(16'h4000, 16'h4000, 16'sd0, 16'sd0, 16'sd0, 16'sd0);
    add_req(16'h4100, 16'h4800, 1'b1);
    add_req(16'h0000, 16'hFFFF, 1'b1);
    drain();

    // Extreme register values, negative determinant.
    set_camera(16'hFFFF, 16'hFFFF, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000);
    add_req(16'd0, 16'd0, 1'b1);
    add_req(16'hFF00, 16'hFE00, 1'b1);
    add_random(60);
    drain();

    // Assorted camera settings with random sprites.
    repeat (6) begin
      set_camera(16'($urandom), 16'($urandom), 16'($urandom_range(0, 65535)),
                 16'($urandom), 16'($urandom), 16'($urandom));
      add_random(40);
      drain();
    end
    set_camera(16'h8000, 16'h8000, 16'sd0, 16'hC000, 16'hD5C3, 16'sd0);
    add_random(100);
    drain();
    set_camera(16'h2000, 16'h6000, 16'sd16384, 16'sd0, 16'sd0, 16'sd10813);
    add_random(100);
    drain();

    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
